[hw/rtl/alfr_pkg.sv]
// Shared types and constants for the additive lagged-Fibonacci generator.
// Used by alfr_table, alfr_mac and the top level; depends on nothing.
`timescale 1ns / 1ps

package alfr_pkg;

    localparam int TABLE_DEPTH = 55;
    localparam int IDX_W       = 6;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = 6;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam word_t LCG_MULT       = 32'd8323199;
    localparam word_t LCG_INC        = 32'd1;
    localparam word_t LCG_RESET      = 32'd1;
    localparam idx_t  LONG_LAG_START = 6'd31;
    localparam idx_t  SHORT_LAG_START = 6'd0;
    localparam idx_t  LAST_IDX       = idx_t'(TABLE_DEPTH - 1);
    localparam cnt_t  MIN_PARITY     = 6'd5;

    // Item kinds carried on the input tuser
    typedef enum logic {
        OP_SEED = 1'b0,
        OP_DRAW = 1'b1
    } op_t;

    // Table write port
    typedef struct packed {
        logic  en;
        idx_t  addr;
        word_t data;
    } tbl_wr_t;

    // Step a lag index, wrapping at the end of the table
    function automatic idx_t step_idx(input idx_t i);
        return (i >= LAST_IDX) ? idx_t'(0) : i + idx_t'(1);
    endfunction

endpackage

[hw/rtl/alfr_table.sv]
// Lag table: 55-word memory, one write port, two registered read ports.
// Per-entry valid bits make never-written entries read as zero. Uses alfr_pkg.
`timescale 1ns / 1ps

module alfr_table
(
    input  logic            clk,
    input  logic            rst_n,
    input  alfr_pkg::tbl_wr_t wr,
    input  alfr_pkg::idx_t  rd_addr_a,
    input  alfr_pkg::idx_t  rd_addr_b,
    output alfr_pkg::word_t rd_data_a,
    output alfr_pkg::word_t rd_data_b
);
    import alfr_pkg::*;

    word_t                  mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    word_t                  rd_a_reg;
    word_t                  rd_b_reg;
    logic                   rd_va_reg;
    logic                   rd_vb_reg;

    // Storage array and read data
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    // Valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_va_reg <= 1'b0;
            rd_vb_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_va_reg <= valid_reg[rd_addr_a];
            rd_vb_reg <= valid_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_va_reg ? rd_a_reg : '0;
    assign rd_data_b = rd_vb_reg ? rd_b_reg : '0;

endmodule

[hw/rtl/alfr_mac.sv]
// Shared multiply-add unit: y = a * b + c mod 2^32.
// Serves the congruential step and the lagged sum. Uses alfr_pkg.
`timescale 1ns / 1ps

module alfr_mac
(
    input  alfr_pkg::word_t a,
    input  alfr_pkg::word_t b,
    input  alfr_pkg::word_t c,
    output alfr_pkg::word_t y
);
    import alfr_pkg::*;

    word_t prod;

    // Low word of the product, then the addend
    assign prod = a * b;
    assign y    = prod + c;

endmodule

[hw/rtl/additive_lagged_fibonacci_rng_top.sv]
// Top level of the additive lagged-Fibonacci generator (lags 55 and 24).
// Sequencer and output register; uses alfr_pkg, alfr_table, alfr_mac.
//
// Usage:
//   Input stream: s_tuser[0] is the kind (0 = seed, 1 = draw), s_tdata
//   carries the 32-bit signed seed (ignored on a draw). A word is taken
//   when s_tvalid and s_tready are high at a rising edge.
//   Output stream: one word per draw on m_tdata, the magnitude of the
//   signed 32-bit lagged sum. A seed gives no output word.
//   Timing: a draw runs read, add/write-back and output load in turn;
//   its word shows on m_tvalid in the same cycle as s_tready comes back,
//   so no new word is taken until the draw is through. The table has a
//   single write port and the multiply-add unit is shared. A seed walks
//   the table one entry per cycle, again from entry 0 while fewer than 5
//   of either parity were written, then idles before taking a new word.
//   Reset: table reads as all zero (draws give 0 until a seed), long-lag
//   index 31, short-lag index 0, congruential state 1.
//   Stall: the output register holds its word until m_tready. A new
//   input word is still taken; a finished draw then waits for the
//   register to free up and s_tready stays low meanwhile.
`timescale 1ns / 1ps

module additive_lagged_fibonacci_rng_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed_value
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] value
);
    import alfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_READ,
        S_CALC,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    idx_t    long_reg, long_next;
    idx_t    short_reg, short_next;
    idx_t    fill_reg, fill_next;
    word_t   lcg_reg, lcg_next;
    cnt_t    odd_reg, odd_next;
    cnt_t    even_reg, even_next;
    logic    valid_reg, valid_next;
    word_t   sum_reg, sum_next;
    word_t   data_reg, data_next;

    tbl_wr_t tbl_wr;
    word_t   rd_long;
    word_t   rd_short;
    word_t   mac_a;
    word_t   mac_b;
    word_t   mac_c;
    word_t   mac_y;
    cnt_t    odd_sum;
    cnt_t    even_sum;
    word_t   mag;

    alfr_table u_table
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (tbl_wr),
        .rd_addr_a (long_reg),
        .rd_addr_b (short_reg),
        .rd_data_a (rd_long),
        .rd_data_b (rd_short)
    );

    alfr_mac u_mac
    (
        .a (mac_a),
        .b (mac_b),
        .c (mac_c),
        .y (mac_y)
    );

    // Parity tallies including the word written this cycle
    assign odd_sum  = odd_reg + cnt_t'(mac_y[0]);
    assign even_sum = even_reg + cnt_t'(!mac_y[0]);

    // Magnitude of the signed sum; -2^31 maps to 0x80000000
    assign mag = sum_reg[WORD_W-1] ? (~sum_reg + word_t'(1)) : sum_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        long_next  = long_reg;
        short_next = short_reg;
        fill_next  = fill_reg;
        lcg_next   = lcg_reg;
        odd_next   = odd_reg;
        even_next  = even_reg;
        valid_next = valid_reg;
        sum_next   = sum_reg;
        data_next  = data_reg;
        tbl_wr     = '0;
        mac_a      = rd_long;
        mac_b      = word_t'(1);
        mac_c      = rd_short;

        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == OP_DRAW)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        lcg_next   = s_tdata;
                        fill_next  = '0;
                        odd_next   = '0;
                        even_next  = '0;
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                mac_a       = lcg_reg;
                mac_b       = LCG_MULT;
                mac_c       = LCG_INC;
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = fill_reg;
                tbl_wr.data = mac_y;
                lcg_next    = mac_y;
                if (fill_reg == LAST_IDX)
                begin
                    if ((odd_sum < MIN_PARITY) || (even_sum < MIN_PARITY))
                    begin
                        // too few of one parity: fill again
                        fill_next = '0;
                        odd_next  = '0;
                        even_next = '0;
                    end
                    else
                    begin
                        long_next  = LONG_LAG_START;
                        short_next = SHORT_LAG_START;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    fill_next = step_idx(fill_reg);
                    odd_next  = odd_sum;
                    even_next = even_sum;
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = short_reg;
                tbl_wr.data = mac_y;
                sum_next    = mac_y;
                long_next   = step_idx(long_reg);
                short_next  = step_idx(short_reg);
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!valid_reg || m_tready)
                begin
                    valid_next = 1'b1;
                    data_next  = mag;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            long_reg  <= LONG_LAG_START;
            short_reg <= SHORT_LAG_START;
            fill_reg  <= '0;
            lcg_reg   <= LCG_RESET;
            odd_reg   <= '0;
            even_reg  <= '0;
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            data_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            long_reg  <= long_next;
            short_reg <= short_next;
            fill_reg  <= fill_next;
            lcg_reg   <= lcg_next;
            odd_reg   <= odd_next;
            even_reg  <= even_next;
            valid_reg <= valid_next;
            sum_reg   <= sum_next;
            data_reg  <= data_next;
        end
    end

endmodule

[hw/rtl/alfr_checker.sv]
// Port-level checks for the additive lagged-Fibonacci generator.
// Bound to additive_lagged_fibonacci_rng_top; uses no package.
`timescale 1ns / 1ps

module alfr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Stalled output word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // Stalled output word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    // A magnitude never exceeds 2^31
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[31] || (m_tdata[30:0] == 31'd0)))
        else $error("output magnitude out of range");

    // One word at a time: busy right after an accepted word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // A seed makes no output word appear
    a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("seed produced an output word");

endmodule

bind additive_lagged_fibonacci_rng_top alfr_checker u_alfr_checker (.*);
